### sv/rc4s_pkg.sv
`timescale 1ns / 1ps

package rc4s_pkg;

  localparam int unsigned KeyMaxDef = 256;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PermDepth = 256;

  // datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_KEY,
    OP_DATA,
    OP_INIT,
    OP_MIX_RD,
    OP_MIX_J,
    OP_MIX_WN,
    OP_MIX_WJ,
    OP_D_J,
    OP_D_WI,
    OP_D_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic fire;  // result goes to the output register this cycle
  } cmd_t;

  typedef struct packed {
    logic n_last;    // sweep counter on its final entry
    logic out_free;  // output register can take a result
  } status_t;

endpackage

### sv/rc4s_ctrl.sv
`timescale 1ns / 1ps

module rc4s_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             s_opcode_i,
  input  logic             s_last_i,
  output logic             s_ready_o,
  input  rc4s_pkg::status_t status_i,
  output rc4s_pkg::cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MIX_RD,
    ST_MIX_J,
    ST_MIX_WN,
    ST_MIX_WJ,
    ST_D_J,
    ST_D_WI,
    ST_D_OUT
  } state_e;

  state_e state_q, state_d;
  logic   sched_q, sched_d;

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    sched_d    = sched_q;
    cmd_o.op   = rc4s_pkg::OP_IDLE;
    cmd_o.fire = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.op = rc4s_pkg::OP_INIT;
        if (status_i.n_last) begin
          state_d = sched_q ? ST_MIX_RD : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_valid_i) begin
          if (s_opcode_i) begin
            cmd_o.op = rc4s_pkg::OP_DATA;
            state_d  = ST_D_J;
          end else begin
            cmd_o.op = rc4s_pkg::OP_KEY;
            if (s_last_i) begin
              sched_d = 1'b1;
              state_d = ST_INIT;
            end
          end
        end
      end
      ST_MIX_RD: begin
        cmd_o.op = rc4s_pkg::OP_MIX_RD;
        state_d  = ST_MIX_J;
      end
      ST_MIX_J: begin
        cmd_o.op = rc4s_pkg::OP_MIX_J;
        state_d  = ST_MIX_WN;
      end
      ST_MIX_WN: begin
        cmd_o.op = rc4s_pkg::OP_MIX_WN;
        state_d  = ST_MIX_WJ;
      end
      ST_MIX_WJ: begin
        cmd_o.op = rc4s_pkg::OP_MIX_WJ;
        if (status_i.n_last) begin
          sched_d = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MIX_RD;
        end
      end
      ST_D_J: begin
        cmd_o.op = rc4s_pkg::OP_D_J;
        state_d  = ST_D_WI;
      end
      ST_D_WI: begin
        cmd_o.op = rc4s_pkg::OP_D_WI;
        state_d  = ST_D_OUT;
      end
      ST_D_OUT: begin
        cmd_o.op = rc4s_pkg::OP_D_OUT;
        if (status_i.out_free) begin
          cmd_o.fire = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sched_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sched_q <= sched_d;
    end
  end

endmodule

### sv/rc4s_datapath.sv
`timescale 1ns / 1ps

module rc4s_datapath #(
  parameter int unsigned KeyMax = rc4s_pkg::KeyMaxDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rc4s_pkg::cmd_t               cmd_i,
  output rc4s_pkg::status_t            status_o,
  input  logic [rc4s_pkg::ByteW-1:0]   byte_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rc4s_pkg::ByteW-1:0]   out_byte_o
);

  localparam int unsigned BW    = rc4s_pkg::ByteW;
  localparam int unsigned KIdxW = (KeyMax > 1) ? $clog2(KeyMax) : 1;
  localparam int unsigned KCntW = $clog2(KeyMax + 1);

  logic [BW-1:0] perm_mem [rc4s_pkg::PermDepth];
  logic [BW-1:0] key_mem  [KeyMax];

  logic [BW-1:0] perm_rd_q, key_rd_q;
  logic [BW-1:0] raddr, waddr, wdata;
  logic          we;

  logic [BW-1:0]    i_q, j_q, n_q;
  logic [KIdxW-1:0] k_q;
  logic [KCntW-1:0] key_cnt_q, key_cnt_next, klen_q, k_next;
  logic             key_we;
  logic             out_valid_q;
  logic             last_q;

  logic [BW-1:0] si_q, sj_q, t_q, b_q, out_byte_q;
  logic [BW-1:0] j_mix, ks;

  assign key_we       = (cmd_i.op == rc4s_pkg::OP_KEY) && (key_cnt_q < KCntW'(KeyMax));
  assign key_cnt_next = key_cnt_q + KCntW'(key_we);
  assign k_next       = KCntW'(k_q) + KCntW'(1);
  assign j_mix        = j_q + perm_rd_q + key_rd_q;

  // the read of entry t was taken before the swap landed in memory for entries i and j, so forward them
  assign ks = (t_q == j_q) ? si_q : ((t_q == i_q) ? sj_q : perm_rd_q);

  assign status_o.n_last   = (n_q == BW'(rc4s_pkg::PermDepth - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;

  always_comb begin
    raddr = t_q;
    waddr = n_q;
    wdata = n_q;
    we    = 1'b0;
    case (cmd_i.op)
      rc4s_pkg::OP_INIT: begin
        we = 1'b1;
      end
      rc4s_pkg::OP_MIX_RD: begin
        raddr = n_q;
      end
      rc4s_pkg::OP_MIX_J: begin
        raddr = j_mix;
      end
      rc4s_pkg::OP_MIX_WN: begin
        we    = 1'b1;
        wdata = perm_rd_q;
      end
      rc4s_pkg::OP_MIX_WJ: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
      end
      rc4s_pkg::OP_DATA: begin
        raddr = i_q + BW'(1);
      end
      rc4s_pkg::OP_D_J: begin
        raddr = j_q + perm_rd_q;
      end
      rc4s_pkg::OP_D_WI: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = perm_rd_q;
        raddr = si_q + perm_rd_q;
      end
      rc4s_pkg::OP_D_OUT: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // permutation and key store: read-first, registered read data
  always_ff @(posedge clk_i) begin
    perm_rd_q <= perm_mem[raddr];
    if (we) begin
      perm_mem[waddr] <= wdata;
    end
    key_rd_q <= key_mem[k_q];
    if (key_we) begin
      key_mem[key_cnt_q[KIdxW-1:0]] <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      k_q         <= '0;
      key_cnt_q   <= '0;
      klen_q      <= KCntW'(1);
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cmd_i.fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        rc4s_pkg::OP_KEY: begin
          if (last_i) begin
            klen_q    <= key_cnt_next;
            key_cnt_q <= '0;
            k_q       <= '0;
            j_q       <= '0;
            i_q       <= '0;
          end else begin
            key_cnt_q <= key_cnt_next;
          end
        end
        rc4s_pkg::OP_INIT: begin
          n_q <= n_q + BW'(1);
        end
        rc4s_pkg::OP_MIX_J: begin
          j_q <= j_mix;
        end
        rc4s_pkg::OP_MIX_WJ: begin
          n_q <= n_q + BW'(1);
          k_q <= (k_next == klen_q) ? '0 : k_next[KIdxW-1:0];
          if (status_o.n_last) begin
            i_q <= '0;
            j_q <= '0;
          end
        end
        rc4s_pkg::OP_DATA: begin
          i_q    <= i_q + BW'(1);
          last_q <= last_i;
        end
        rc4s_pkg::OP_D_J: begin
          j_q <= j_q + perm_rd_q;
        end
        rc4s_pkg::OP_D_OUT: begin
          if (cmd_i.fire && last_q) begin
            i_q <= '0;
            j_q <= '0;
          end
        end
        default: begin
          n_q <= n_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rc4s_pkg::OP_MIX_J: si_q <= perm_rd_q;
      rc4s_pkg::OP_DATA:  b_q  <= byte_i;
      rc4s_pkg::OP_D_J:   si_q <= perm_rd_q;
      rc4s_pkg::OP_D_WI: begin
        sj_q <= perm_rd_q;
        t_q  <= si_q + perm_rd_q;
      end
      default: begin
        t_q <= t_q;
      end
    endcase
    if (cmd_i.fire) begin
      out_byte_q <= b_q ^ ks;
    end
  end

endmodule

### sv/rc4_stream_cipher.sv
`timescale 1ns / 1ps

// rc4 cipher engine with one stream input and one stream output
// input transfers carry a byte in tdata and the kind in tuser: 0 key byte, 1 data byte
// key bytes fill the key store one per cycle; the key byte with tlast set starts
// the key schedule, which rebuilds the identity permutation and then mixes in
// the key one swap at a time (read S[n], read S[j], write S[n], write S[j]) on a
// permutation memory with one read and one write port; no input is taken meanwhile
// each data byte gives one output byte, data XOR keystream, loaded into the output
// register in the D_OUT state, after the D_J and D_WI states, once the register is
// free; a new item can be taken in the cycle after that, so the engine takes no new
// byte until its read, read, write-and-read, write sequence on the memory is done
// a data byte with tlast set restarts the stream indices for the next message
// after reset the permutation is filled with identity while
// s_axis_tready_o is low; data sent before any key runs on that permutation
// when the receiver stalls the result waits in the output register and the
// engine holds its finished item until the register frees
module rc4_stream_cipher #(
  parameter int unsigned KeyMax = rc4s_pkg::KeyMaxDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [rc4s_pkg::ByteW-1:0] s_axis_tdata_i,   // byte_in [7:0]
  input  logic                       s_axis_tuser_i,   // opcode [0]
  input  logic                       s_axis_tlast_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [rc4s_pkg::ByteW-1:0] m_axis_tdata_o    // byte_out [7:0]
);

  rc4s_pkg::cmd_t    cmd;
  rc4s_pkg::status_t status;

  rc4s_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_opcode_i (s_axis_tuser_i),
    .s_last_i   (s_axis_tlast_i),
    .s_ready_o  (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rc4s_datapath #(
    .KeyMax (KeyMax)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o)
  );

  // a data transfer occupies the engine for its whole sequence
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i) |=> !s_axis_tready_o)
    else $error("input taken while a data byte is in flight");

  // final key byte must start the schedule
  a_key_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i && s_axis_tlast_i)
      |=> !s_axis_tready_o)
    else $error("key schedule did not start");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result loaded over a pending one");

  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fire |=> m_axis_tvalid_o)
    else $error("result lost after load");

endmodule
